// ----- hw/rtl/pfc_pkg.sv -----
package pfc_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 128;
    localparam int unsigned FRAME_OVERHEAD   = 7;
    localparam int unsigned SIZE_ADD         = 3;

    localparam logic [7:0]  START_BYTE = 8'hDA;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] packet_kind;
        logic [6:0] payload_len;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEQ,
        ST_SIZE_LO,
        ST_SIZE_HI,
        ST_KIND,
        ST_CRC_HI,
        ST_CRC_LO
    } state_t;

    // reflected crc-16, one byte lsb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ b[k])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/packet_framer_crc16_unit.sv -----
// Transmit packet framer with reflected CRC-16 (poly 0x8408, init 0xFFFF, sent
// inverted, high byte first). Each accepted word produces its framed bytes one
// per cycle on the result channel unless it stalls: a payload word gives
// one byte (three for the final payload byte of a packet, which also sends the
// CRC), a start word 5 bytes (7 when the payload is empty), and an error
// word one byte. The single output byte register moves one byte per cycle when
// not stalled; the CRC is updated as each sequence, size, kind or payload byte
// enters that register. A new word is taken once the framer is back in idle
// and the output register can accept a byte, so payload words stream at one
// per cycle while the result is not stalled. No clearing after reset.
module packet_framer_crc16_unit #(
    parameter int unsigned BUFFER_BYTES = pfc_pkg::BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfc_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_stall,
    output pfc_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall
);

    logic             load_ok;
    logic             load;
    pfc_pkg::result_t load_word;

    pfc_framer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .load_ok    (load_ok),
        .load       (load),
        .load_word  (load_word)
    );

    pfc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_word    (load_word),
        .load_ok      (load_ok),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ----- hw/rtl/pfc_out_reg.sv -----
module pfc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pfc_pkg::result_t  load_word,
    output logic              load_ok,
    output pfc_pkg::result_t  result,
    output logic              result_valid,
    input  logic              result_stall
);

    logic             valid_reg;
    logic             valid_next;
    pfc_pkg::result_t word_reg;

    assign load_ok      = !valid_reg || !result_stall;
    assign result       = word_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && load)
        begin
            word_reg <= load_word;
        end
    end

endmodule

// ----- hw/rtl/pfc_framer.sv -----
module pfc_framer #(
    parameter int unsigned BUFFER_BYTES = pfc_pkg::BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfc_pkg::item_t    item,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              load_ok,
    output logic              load,
    output pfc_pkg::result_t  load_word
);

    localparam int unsigned LenLimit = BUFFER_BYTES - pfc_pkg::FRAME_OVERHEAD;

    pfc_pkg::state_t state_reg;
    pfc_pkg::state_t state_next;
    logic [7:0]      seq_count_reg;
    logic [7:0]      seq_count_next;
    logic [15:0]     crc_reg;
    logic [15:0]     crc_next;
    logic [6:0]      bytes_left_reg;
    logic [6:0]      bytes_left_next;
    logic            frame_open_reg;
    logic            frame_open_next;
    logic [7:0]      kind_reg;
    logic [7:0]      kind_next;
    logic [7:0]      size_lo_reg;
    logic [7:0]      size_lo_next;
    logic            take;
    logic            oversize;
    logic [15:0]     crc_inv;

    assign take       = (state_reg == pfc_pkg::ST_IDLE) && load_ok && item_valid;
    assign item_stall = !((state_reg == pfc_pkg::ST_IDLE) && load_ok);
    assign oversize   = 32'(item.payload_len) > LenLimit;
    assign crc_inv    = ~crc_reg;

    always_comb
    begin
        state_next      = state_reg;
        seq_count_next  = seq_count_reg;
        crc_next        = crc_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        kind_next       = kind_reg;
        size_lo_next    = size_lo_reg;
        load            = 1'b0;
        load_word       = '0;
        if (load_ok)
        begin
            unique case (state_reg)
                pfc_pkg::ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        load = 1'b1;
                        if (item.func == pfc_pkg::FUNC_START)
                        begin
                            if (oversize)
                            begin
                                load_word.last  = 1'b1;
                                load_word.error = 1'b1;
                            end
                            else
                            begin
                                load_word.out_byte = pfc_pkg::START_BYTE;
                                seq_count_next     = seq_count_reg + 8'd1;
                                crc_next           = pfc_pkg::CRC_INIT;
                                kind_next          = item.packet_kind;
                                size_lo_next       = {1'b0, item.payload_len}
                                                     + 8'(pfc_pkg::SIZE_ADD);
                                bytes_left_next    = item.payload_len;
                                frame_open_next    = 1'b1;
                                state_next         = pfc_pkg::ST_SEQ;
                            end
                        end
                        else if (!frame_open_reg || bytes_left_reg == 7'd0)
                        begin
                            load_word.last  = 1'b1;
                            load_word.error = 1'b1;
                        end
                        else
                        begin
                            load_word.out_byte = item.data_byte;
                            crc_next           = pfc_pkg::crc_feed(crc_reg, item.data_byte);
                            bytes_left_next    = bytes_left_reg - 7'd1;
                            if (bytes_left_reg == 7'd1)
                            begin
                                state_next = pfc_pkg::ST_CRC_HI;
                            end
                        end
                    end
                end
                pfc_pkg::ST_SEQ:
                begin
                    load               = 1'b1;
                    load_word.out_byte = seq_count_reg;
                    crc_next           = pfc_pkg::crc_feed(crc_reg, seq_count_reg);
                    state_next         = pfc_pkg::ST_SIZE_LO;
                end
                pfc_pkg::ST_SIZE_LO:
                begin
                    load               = 1'b1;
                    load_word.out_byte = size_lo_reg;
                    crc_next           = pfc_pkg::crc_feed(crc_reg, size_lo_reg);
                    state_next         = pfc_pkg::ST_SIZE_HI;
                end
                pfc_pkg::ST_SIZE_HI:
                begin
                    // size never reaches 256, high byte is zero
                    load               = 1'b1;
                    load_word.out_byte = 8'h00;
                    crc_next           = pfc_pkg::crc_feed(crc_reg, 8'h00);
                    state_next         = pfc_pkg::ST_KIND;
                end
                pfc_pkg::ST_KIND:
                begin
                    load               = 1'b1;
                    load_word.out_byte = kind_reg;
                    crc_next           = pfc_pkg::crc_feed(crc_reg, kind_reg);
                    if (bytes_left_reg == 7'd0)
                    begin
                        state_next = pfc_pkg::ST_CRC_HI;
                    end
                    else
                    begin
                        state_next = pfc_pkg::ST_IDLE;
                    end
                end
                pfc_pkg::ST_CRC_HI:
                begin
                    load               = 1'b1;
                    load_word.out_byte = crc_inv[15:8];
                    state_next         = pfc_pkg::ST_CRC_LO;
                end
                pfc_pkg::ST_CRC_LO:
                begin
                    load               = 1'b1;
                    load_word.out_byte = crc_inv[7:0];
                    load_word.last     = 1'b1;
                    crc_next           = pfc_pkg::CRC_INIT;
                    bytes_left_next    = 7'd0;
                    frame_open_next    = 1'b0;
                    state_next         = pfc_pkg::ST_IDLE;
                end
                default:
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfc_pkg::ST_IDLE;
            seq_count_reg  <= 8'd0;
            crc_reg        <= pfc_pkg::CRC_INIT;
            bytes_left_reg <= 7'd0;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seq_count_reg  <= seq_count_next;
            crc_reg        <= crc_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg    <= kind_next;
            size_lo_reg <= size_lo_next;
        end
    end

endmodule
